FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, cond)

`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/core/cerx_pkg.sv
// ----------------------------------------------------------------------------
// cerx_pkg
// Types, widths and helpers for the column edge run extractor.
// ----------------------------------------------------------------------------
package cerx_pkg;

  localparam int COLUMN_LIMIT = 1024;
  localparam int ROW_W        = $clog2(COLUMN_LIMIT + 1);
  localparam int START_W      = $clog2(COLUMN_LIMIT);

  localparam int PIX_W  = 8;
  localparam int THR_W  = 8;
  localparam int RUN_W  = 11;
  localparam int GRAD_W = 12;
  localparam int MAG_W  = (ROW_W > RUN_W) ? ROW_W : RUN_W;

  localparam int RUN_MAX = 1023;
  localparam logic [THR_W-1:0] THR_RESET = 8'd20;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_UNKNOWN = 3'b001,
    ST_DARK    = 3'b010,
    ST_BRIGHT  = 3'b100
  } edge_state_t;

  typedef struct packed {
    logic signed [RUN_W-1:0] run_length;
    logic                    last_of_column;
  } run_item_t;

  function automatic run_item_t make_run(input logic [MAG_W-1:0] mag,
                                         input logic negative,
                                         input logic last);
    logic [RUN_W-1:0] m;
    run_item_t        r;
    m = (mag > MAG_W'(RUN_MAX)) ? RUN_W'(RUN_MAX) : mag[RUN_W-1:0];
    r.run_length     = negative ? $signed(-m) : $signed(m);
    r.last_of_column = last;
    return r;
  endfunction

endpackage

FILE: rtl/core/pixel_if.sv
// ----------------------------------------------------------------------------
// pixel_if
// Valid/ready channel carrying one column pixel and its column marks.
// ----------------------------------------------------------------------------
interface pixel_if;
  import cerx_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             column_start;
  logic             column_end;

  modport source (output valid, output pixel, output column_start,
                  output column_end, input ready);
  modport sink   (input valid, input pixel, input column_start,
                  input column_end, output ready);
endinterface

FILE: rtl/core/run_if.sv
// ----------------------------------------------------------------------------
// run_if
// Valid/ready channel carrying one signed run length.
// ----------------------------------------------------------------------------
interface run_if;
  import cerx_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RUN_W-1:0] run_length;
  logic                    last_of_column;

  modport source (output valid, output run_length, output last_of_column,
                  input ready);
  modport sink   (input valid, input run_length, input last_of_column,
                  output ready);
endinterface

FILE: rtl/core/column_edge_run_extractor_top.sv
// ----------------------------------------------------------------------------
// column_edge_run_extractor_top
// Edge detector and run-length tracker over one image column.
// ----------------------------------------------------------------------------
// Pixels enter on the pixels channel, top to bottom, one item per pixel, with
// column_start on the top pixel and column_end on the bottom one. Signed runs
// leave on the runs channel: positive for a bright run, negative for dark,
// zero for a column with no edge; last_of_column marks the column flush.
// The gradient, edge compare and tracker update are done in the cycle the
// pixel is taken; its results (zero, one or two) land in a four-entry output
// queue feeding runs. Throughput: one pixel per cycle while pixels.ready is
// high, i.e. the queue has room for two results, so a stalled receiver holds
// off input once three results are pending; the queue drains one result per
// cycle while runs.ready is high. cfg_we/cfg_wdata write the edge threshold
// (reset 20); the user must write it only while idle (not enforced). rst
// (synchronous) empties the queue, clears the window, the row counter and
// the tracker and restores the threshold; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module column_edge_run_extractor_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [cerx_pkg::THR_W-1:0] cfg_wdata,
  pixel_if.sink                     pixels,
  run_if.source                     runs
);
  import cerx_pkg::*;

  logic [THR_W-1:0]   edge_threshold;
  logic [PIX_W-1:0]   pixel_window [4];
  logic [ROW_W-1:0]   row_index;
  edge_state_t        edge_state;
  logic [START_W-1:0] run_start_row;

  run_item_t          fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head;
  logic [FIFO_AW-1:0] tail;
  logic [CNT_W-1:0]   count;

  logic                     accept;
  logic                     pop;
  logic [ROW_W-1:0]         r;
  edge_state_t              st0;
  edge_state_t              st1;
  logic [START_W-1:0]       s0;
  logic [START_W-1:0]       s1;
  logic                     win_ok;
  logic [START_W-1:0]       i_row;
  logic signed [GRAD_W-1:0] grad;
  logic signed [GRAD_W-1:0] t6;
  logic                     rise;
  logic                     fall;
  logic                     edge_emit;
  logic [ROW_W-1:0]         edge_mag;
  logic [ROW_W-1:0]         rc;
  logic [ROW_W-1:0]         end_row;
  logic [ROW_W-1:0]         flush_mag;
  run_item_t                edge_item;
  run_item_t                flush_item;
  run_item_t                entry0;
  logic [1:0]               push_cnt;

  assign accept       = pixels.valid && pixels.ready;
  assign pop          = runs.valid && runs.ready;
  assign pixels.ready = (count <= CNT_W'(FIFO_DEPTH - 2));

  assign runs.valid          = (count != '0);
  assign runs.run_length     = fifo[head].run_length;
  assign runs.last_of_column = fifo[head].last_of_column;

  always_comb begin
    r  = pixels.column_start ? '0 : row_index;
    st0 = pixels.column_start ? ST_UNKNOWN : edge_state;
    s0 = pixels.column_start ? '0 : run_start_row;

    win_ok = (r >= ROW_W'(4)) && (r < ROW_W'(COLUMN_LIMIT));
    i_row  = START_W'(r - ROW_W'(2));

    grad = $signed({4'b0, pixel_window[0]}) + $signed({3'b0, pixel_window[1], 1'b0})
         - $signed({3'b0, pixel_window[3], 1'b0}) - $signed({4'b0, pixels.pixel});
    t6   = $signed({2'b0, edge_threshold, 2'b0}) + $signed({3'b0, edge_threshold, 1'b0});
    rise = win_ok && (grad > t6);
    fall = win_ok && (grad < -t6);

    st1       = st0;
    s1        = s0;
    edge_emit = 1'b0;
    case (st0)
      ST_UNKNOWN: begin
        if (rise) begin
          st1 = ST_BRIGHT;
          s1  = i_row;
        end else if (fall) begin
          st1 = ST_DARK;
          s1  = i_row;
        end
      end
      ST_DARK: begin
        if (rise) begin
          st1       = ST_BRIGHT;
          s1        = i_row;
          edge_emit = 1'b1;
        end
      end
      ST_BRIGHT: begin
        if (fall) begin
          st1       = ST_DARK;
          s1        = i_row;
          edge_emit = 1'b1;
        end
      end
      default: begin
        st1 = ST_UNKNOWN;
      end
    endcase

    edge_mag  = ROW_W'(i_row) - ROW_W'(s0);
    edge_item = make_run(MAG_W'(edge_mag), (st0 == ST_DARK), 1'b0);

    rc        = (r < ROW_W'(COLUMN_LIMIT)) ? r : ROW_W'(COLUMN_LIMIT - 1);
    end_row   = rc - ROW_W'(1);
    flush_mag = (st1 != ST_UNKNOWN && end_row >= ROW_W'(s1)) ?
                (end_row - ROW_W'(s1)) : '0;
    flush_item = make_run(MAG_W'(flush_mag), (st1 == ST_DARK), 1'b1);

    entry0   = edge_emit ? edge_item : flush_item;
    push_cnt = 2'(edge_emit) + 2'(pixels.column_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= THR_RESET;
    end else if (cfg_we) begin
      edge_threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_window[0] <= '0;
      pixel_window[1] <= '0;
      pixel_window[2] <= '0;
      pixel_window[3] <= '0;
      row_index       <= '0;
      edge_state      <= ST_UNKNOWN;
      run_start_row   <= '0;
    end else if (accept) begin
      pixel_window[0] <= pixel_window[1];
      pixel_window[1] <= pixel_window[2];
      pixel_window[2] <= pixel_window[3];
      pixel_window[3] <= pixels.pixel;
      if (pixels.column_end) begin
        row_index     <= '0;
        edge_state    <= ST_UNKNOWN;
        run_start_row <= '0;
      end else begin
        row_index     <= (r < ROW_W'(COLUMN_LIMIT)) ? r + ROW_W'(1) : ROW_W'(COLUMN_LIMIT);
        edge_state    <= st1;
        run_start_row <= s1;
      end
    end
  end

  // output queue
  always_ff @(posedge clk) begin
    if (accept && push_cnt != 2'd0) begin
      fifo[tail] <= entry0;
    end
    if (accept && push_cnt == 2'd2) begin
      fifo[tail + FIFO_AW'(1)] <= flush_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + FIFO_AW'(1);
      end
      if (accept) begin
        tail <= tail + FIFO_AW'(push_cnt);
      end
      count <= count + (accept ? CNT_W'(push_cnt) : '0) - CNT_W'(pop);
    end
  end

  `ASSERT_ALWAYS(a_queue_bound, count <= CNT_W'(FIFO_DEPTH))
  `ASSERT_NEXT(a_end_resets, accept && pixels.column_end, edge_state == ST_UNKNOWN && row_index == '0)
  `ASSERT_ALWAYS(a_start_behind, edge_state == ST_UNKNOWN || ROW_W'(run_start_row) < row_index)

endmodule
